@@ src/bbf_pkg.sv @@
package bbf_pkg;

    localparam int LANES      = 8;
    localparam int LANE_BITS  = 64;
    localparam int LANE_IDX_W = 6;
    localparam int BLOCK_W    = LANES * LANE_BITS;
    localparam int HASH_W     = 64;
    localparam int HALF_W     = 32;
    localparam int COUNT_W    = 11;
    localparam int DIV_STEPS  = HALF_W;
    localparam int STEP_W     = 5;
    localparam int CMD_W      = 2;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CHECK = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    typedef struct packed {
        logic item_load;
        logic div_load;
        logic div_step;
        logic rd_en;
        logic set_en;
        logic chk_en;
        logic row_rst;
        logic row_clr;
        logic init_sweep;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic             div_last;
        logic             row_last;
        logic             out_free;
        logic [CMD_W-1:0] item_cmd;
    } dp_status_t;

    function automatic logic [BLOCK_W-1:0] lane_mask(input logic [HASH_W-1:0] hash);
        logic [BLOCK_W-1:0]    m;
        logic [LANE_IDX_W-1:0] pos;
        m = '0;
        for (int i = 0; i < LANES; i++) begin
            pos = hash[LANE_IDX_W-1:0]
                + LANE_IDX_W'(LANE_IDX_W'(i) * hash[HALF_W +: LANE_IDX_W]);
            m[i * LANE_BITS + int'(pos)] = 1'b1;
        end
        return m;
    endfunction

endpackage

@@ src/bbf_ctrl.sv @@
module bbf_ctrl (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic [bbf_pkg::CMD_W-1:0]      s_tuser,
    output logic                           s_tready,
    output bbf_pkg::dp_cmd_t               cmd,
    input  bbf_pkg::dp_status_t            status
);

    typedef enum logic [6:0] {
        ST_INIT   = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_DIV    = 7'b0000100,
        ST_READ   = 7'b0001000,
        ST_MODIFY = 7'b0010000,
        ST_CLEAR  = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_INIT: begin
                cmd.row_clr    = 1'b1;
                cmd.init_sweep = 1'b1;
                if (status.row_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.item_load = 1'b1;
                    if (s_tuser == bbf_pkg::CMD_ADD || s_tuser == bbf_pkg::CMD_CHECK) begin
                        cmd.div_load = 1'b1;
                        state_next   = ST_DIV;
                    end else if (s_tuser == bbf_pkg::CMD_CLEAR) begin
                        cmd.row_rst = 1'b1;
                        state_next  = ST_CLEAR;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_MODIFY;
            end
            ST_MODIFY: begin
                if (status.item_cmd == bbf_pkg::CMD_ADD) begin
                    cmd.set_en = 1'b1;
                end else begin
                    cmd.chk_en = 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_CLEAR: begin
                cmd.row_clr = 1'b1;
                if (status.row_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

endmodule

@@ src/bbf_datapath.sv @@
module bbf_datapath #(
    parameter int MAX_BLOCKS = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  bbf_pkg::dp_cmd_t                cmd,
    output bbf_pkg::dp_status_t             status,
    input  logic [bbf_pkg::HASH_W-1:0]      s_tdata,
    input  logic [bbf_pkg::CMD_W-1:0]       s_tuser,
    input  logic                            cfg_valid,
    input  logic [bbf_pkg::COUNT_W-1:0]     cfg_data,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic [7:0]                      m_tdata,
    output logic [bbf_pkg::CMD_W-1:0]       m_tuser
);

    localparam int CNT_W = bbf_pkg::COUNT_W;
    localparam int AW    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW    = (AW > CNT_W) ? AW : CNT_W;
    localparam logic [AW-1:0] LAST_ROW = AW'(MAX_BLOCKS - 1);
    localparam logic [16:0]   MAX_CNT  = 17'(MAX_BLOCKS);

    logic [CNT_W-1:0]               bc_reg;
    logic [CNT_W-1:0]               eff_cnt;
    logic [CNT_W-1:0]               eff_last;

    logic [bbf_pkg::HASH_W-1:0]     hash_reg;
    logic [bbf_pkg::CMD_W-1:0]      icmd_reg;

    logic [CNT_W-1:0]               rem_reg, rem_next;
    logic [bbf_pkg::HALF_W-1:0]     dvd_reg;
    logic [bbf_pkg::STEP_W-1:0]     step_reg;
    logic [CNT_W:0]                 trial;
    logic [CNT_W:0]                 trial_sub;
    logic                           fits;

    logic [AW-1:0]                  row_reg;
    logic [AW-1:0]                  blk_addr;

    logic [bbf_pkg::BLOCK_W-1:0]    mem [MAX_BLOCKS];
    logic [bbf_pkg::BLOCK_W-1:0]    rdata_reg;
    logic [bbf_pkg::BLOCK_W-1:0]    mask;
    logic                           wr_en;
    logic [AW-1:0]                  wr_addr;
    logic [bbf_pkg::BLOCK_W-1:0]    wr_data;
    logic                           hit;

    logic                           present_reg;
    logic                           m_tvalid_reg;
    logic                           out_present_reg;
    logic [bbf_pkg::CMD_W-1:0]      out_cmd_reg;

    // block count register and its effective value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bc_reg <= bbf_pkg::COUNT_RESET;
        end else if (cfg_valid) begin
            bc_reg <= cfg_data;
        end
    end

    always_comb begin
        if (bc_reg == '0) begin
            eff_cnt = CNT_W'(1);
        end else if ({6'b0, bc_reg} > MAX_CNT) begin
            eff_cnt = CNT_W'(MAX_BLOCKS);
        end else begin
            eff_cnt = bc_reg;
        end
        eff_last = eff_cnt - CNT_W'(1);
    end

    // item capture
    always_ff @(posedge aclk) begin
        if (cmd.item_load) begin
            hash_reg <= s_tdata;
            icmd_reg <= s_tuser;
        end
    end

    // restoring division, one quotient bit per cycle
    assign trial     = {rem_reg, dvd_reg[bbf_pkg::HALF_W-1]};
    assign fits      = trial >= {1'b0, eff_cnt};
    assign trial_sub = trial - {1'b0, eff_cnt};
    assign rem_next  = fits ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
        end else if (cmd.div_load) begin
            step_reg <= '0;
        end else if (cmd.div_step) begin
            step_reg <= step_reg + bbf_pkg::STEP_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_load) begin
            rem_reg <= '0;
            dvd_reg <= s_tdata[bbf_pkg::HASH_W-1:bbf_pkg::HALF_W];
        end else if (cmd.div_step) begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[bbf_pkg::HALF_W-2:0], 1'b0};
        end
    end

    assign blk_addr = AW'(rem_reg);

    // row counter for clear sweeps
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
        end else if (cmd.row_rst) begin
            row_reg <= '0;
        end else if (cmd.row_clr) begin
            row_reg <= row_reg + AW'(1);
        end
    end

    // block store
    assign mask    = bbf_pkg::lane_mask(hash_reg);
    assign hit     = (rdata_reg & mask) == mask;
    assign wr_en   = cmd.set_en | cmd.row_clr;
    assign wr_addr = cmd.row_clr ? row_reg : blk_addr;
    assign wr_data = cmd.row_clr ? '0 : (rdata_reg | mask);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rdata_reg <= mem[blk_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.item_load) begin
            present_reg <= 1'b0;
        end else if (cmd.chk_en) begin
            present_reg <= hit;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_present_reg <= present_reg;
            out_cmd_reg     <= icmd_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, out_present_reg};
    assign m_tuser  = out_cmd_reg;

    assign status.div_last = step_reg == bbf_pkg::STEP_W'(bbf_pkg::DIV_STEPS - 1);
    assign status.row_last = cmd.init_sweep ? (row_reg == LAST_ROW)
                                            : (CW'(row_reg) == CW'(eff_last));
    assign status.out_free = !m_tvalid_reg || m_tready;
    assign status.item_cmd = icmd_reg;

    a_single_writer: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.set_en && cmd.row_clr))
        else $error("set and clear write in the same cycle");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> status.out_free)
        else $error("result loaded over a pending transfer");

    a_addr_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_en |-> rem_reg < eff_cnt)
        else $error("block index not below block count");

    a_read_used: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_en |=> (cmd.set_en || cmd.chk_en))
        else $error("read data not consumed");

    a_clear_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.row_clr && !cmd.init_sweep) |-> CW'(row_reg) <= CW'(eff_last))
        else $error("clear beyond blocks in use");

endmodule

@@ src/blocked_bloom_filter_core.sv @@
// Blocked Bloom filter over MAX_BLOCKS blocks of 512 bits (eight 64-bit lanes).
// Each input transfer carries a command in s_tuser (0 add, 1 check, 2 clear) and
// a 64-bit hash in s_tdata; every input transfer yields exactly one result with
// the maybe-present flag in m_tdata bit 0 and the echoed command in m_tuser.
// The block is the upper hash half modulo the block count, worked out by a
// restoring divider one bit per cycle; add and check then run the 32 divide
// steps, a store read, the modify or test and the result load, after which the
// result sits in the output register.
// Clear writes one block per cycle over the effective block count; an unused
// command goes straight to the result load.
// After reset the store is zeroed in a sweep over all MAX_BLOCKS blocks during which
// s_tready stays low; block count writes are taken at any time. A finished
// result waits in the output register and the next input transfer is taken
// meanwhile. Block count 0 acts as 1 and values above MAX_BLOCKS as MAX_BLOCKS.
module blocked_bloom_filter_core #(
    parameter int MAX_BLOCKS = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // hash
    input  logic [1:0]  s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // maybe_present, zero fill
    output logic [1:0]  m_tuser,   // done_command
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_data   // block_count
);

    bbf_pkg::dp_cmd_t    dp_cmd;
    bbf_pkg::dp_status_t dp_status;

    assign cfg_ready = 1'b1;

    bbf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .cmd      (dp_cmd),
        .status   (dp_status)
    );

    bbf_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (dp_cmd),
        .status    (dp_status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

@@ bench/tb_blocked_bloom_filter_core.sv @@
module tb_blocked_bloom_filter_core;

    localparam int          FILTER_DEPTH = 1024;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          QUIET_LIMIT  = 5000;
    localparam int          TAIL_CYCLES  = 40;
    localparam int          PHASES       = 6;
    localparam int          PHASE_KEYS   = 170;
    localparam int          KNOWN_KEYS   = 64;
    localparam int          DIR_LEN      = 27;
    localparam logic        ROW_ITEM     = 1'b0;
    localparam logic        ROW_CFG      = 1'b1;
    localparam logic [1:0]  CMD_UNUSED   = 2'd3;
    localparam logic [63:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic        present;
        logic [1:0]  cmd;
    } bbf_result_t;

    typedef struct packed {
        logic        kind;
        logic [10:0] count;
        logic [1:0]  cmd;
        logic [63:0] hash;
        logic        typed;
        logic        present;
    } dir_row_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = '0;   // hash
    logic [1:0]  s_tuser   = '0;   // command
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;          // maybe_present, zero fill
    logic [1:0]  m_tuser;          // done_command
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [10:0] cfg_data  = '0;   // block_count

    logic [bbf_pkg::BLOCK_W-1:0] filter_q [FILTER_DEPTH];
    logic [10:0]                 block_count_q;
    bbf_result_t                 pending_results [$];
    logic [63:0]                 known_keys [$];
    bbf_result_t                 want;

    int err_cnt      = 0;
    int n_keys       = 0;
    int n_checked    = 0;
    int n_hits       = 0;
    int n_clears     = 0;
    int idle_pct     = 0;
    int stall_pct    = 0;
    int hold_reqs    = 0;
    int hold_seen    = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;

    logic [10:0] phase_count [PHASES] = '{11'd13, 11'd1024, 11'd1, 11'd2047, 11'd0, 11'd40};
    int          phase_idle  [PHASES] = '{0, 54, 0, 15, 54, 0};
    int          phase_stall [PHASES] = '{0, 0, 54, 15, 0, 54};

    dir_row_t dir_rows [DIR_LEN] = '{
        '{ROW_ITEM, 11'd0,    bbf_pkg::CMD_CHECK, 64'h0,                   1'b1, 1'b0},
        '{ROW_ITEM, 11'd0,    bbf_pkg::CMD_ADD,   64'h0,                   1'b1, 1'b0},
        '{ROW_ITEM, 11'd0,    bbf_pkg::CMD_CHECK, 64'h0,                   1'b1, 1'b1},
        '{ROW_ITEM, 11'd0,    bbf_pkg::CMD_ADD,   ALL_ONES,                1'b1, 1'b0},
        '{ROW_ITEM, 11'd0,    bbf_pkg::CMD_CHECK, ALL_ONES,                1'b1, 1'b1},
        '{ROW_ITEM, 11'd0,    bbf_pkg::CMD_CHECK, 64'h1,                   1'b1, 1'b0},
        '{ROW_ITEM, 11'd0,    CMD_UNUSED,         ALL_ONES,                1'b1, 1'b0},
        '{ROW_ITEM, 11'd0,    bbf_pkg::CMD_CHECK, ALL_ONES,                1'b1, 1'b1},
        '{ROW_CFG,  11'd0,    bbf_pkg::CMD_ADD,   64'h0,                   1'b0, 1'b0},
        '{ROW_ITEM, 11'd0,    bbf_pkg::CMD_CHECK, 64'hFFFF_FFFF_0000_0000, 1'b0, 1'b0},
        '{ROW_ITEM, 11'd0,    bbf_pkg::CMD_ADD,   64'hFFFF_FFFF_0000_0000, 1'b1, 1'b0},
        '{ROW_ITEM, 11'd0,    bbf_pkg::CMD_CHECK, 64'hFFFF_FFFF_0000_0000, 1'b1, 1'b1},
        '{ROW_ITEM, 11'd0,    bbf_pkg::CMD_CLEAR, 64'h0,                   1'b1, 1'b0},
        '{ROW_ITEM, 11'd0,    bbf_pkg::CMD_CHECK, 64'h0,                   1'b1, 1'b0},
        '{ROW_CFG,  11'd1024, bbf_pkg::CMD_ADD,   64'h0,                   1'b0, 1'b0},
        '{ROW_ITEM, 11'd0,    bbf_pkg::CMD_CHECK, ALL_ONES,                1'b1, 1'b1},
        '{ROW_CFG,  11'd2047, bbf_pkg::CMD_ADD,   64'h0,                   1'b0, 1'b0},
        '{ROW_ITEM, 11'd0,    bbf_pkg::CMD_CHECK, ALL_ONES,                1'b1, 1'b1},
        '{ROW_ITEM, 11'd0,    bbf_pkg::CMD_CLEAR, ALL_ONES,                1'b1, 1'b0},
        '{ROW_ITEM, 11'd0,    bbf_pkg::CMD_CHECK, ALL_ONES,                1'b1, 1'b0},
        '{ROW_CFG,  11'd3,    bbf_pkg::CMD_ADD,   64'h0,                   1'b0, 1'b0},
        '{ROW_ITEM, 11'd0,    bbf_pkg::CMD_ADD,   64'h1234_5678_9ABC_DEF0, 1'b1, 1'b0},
        '{ROW_ITEM, 11'd0,    bbf_pkg::CMD_CHECK, 64'h1234_5678_9ABC_DEF0, 1'b1, 1'b1},
        '{ROW_ITEM, 11'd0,    bbf_pkg::CMD_CHECK, 64'h8000_0000_8000_0000, 1'b0, 1'b0},
        '{ROW_ITEM, 11'd0,    bbf_pkg::CMD_ADD,   64'h5555_5555_AAAA_AAAA, 1'b1, 1'b0},
        '{ROW_ITEM, 11'd0,    bbf_pkg::CMD_CHECK, 64'hAAAA_AAAA_5555_5555, 1'b0, 1'b0},
        '{ROW_ITEM, 11'd0,    CMD_UNUSED,         64'h0,                   1'b1, 1'b0}
    };

    blocked_bloom_filter_core #(
        .MAX_BLOCKS(FILTER_DEPTH)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    function automatic logic [bbf_pkg::BLOCK_W-1:0] key_bits(input logic [63:0] hash);
        logic [bbf_pkg::BLOCK_W-1:0] m;
        logic [31:0]                 sum;
        m = '0;
        for (int i = 0; i < bbf_pkg::LANES; i++) begin
            sum = hash[31:0] + 32'(i) * hash[63:32];
            m[i * bbf_pkg::LANE_BITS + int'(sum[5:0])] = 1'b1;
        end
        return m;
    endfunction

    // updates the filter image and returns the maybe-present flag
    function automatic logic filter_apply(input logic [1:0] cmd, input logic [63:0] hash);
        int unsigned                 span;
        int unsigned                 blk;
        logic [bbf_pkg::BLOCK_W-1:0] bits;
        logic                        hit;
        span = (block_count_q == 0) ? 1 :
               (block_count_q > FILTER_DEPTH) ? FILTER_DEPTH : block_count_q;
        blk  = hash[63:32] % span;
        bits = key_bits(hash);
        hit  = 1'b0;
        case (cmd)
            bbf_pkg::CMD_ADD: begin
                filter_q[blk] = filter_q[blk] | bits;
            end
            bbf_pkg::CMD_CHECK: begin
                hit = ((filter_q[blk] & bits) == bits);
            end
            bbf_pkg::CMD_CLEAR: begin
                for (int b = 0; b < span; b++)
                    filter_q[b] = '0;
            end
            default: ;
        endcase
        return hit;
    endfunction

    task automatic send_key(input logic [1:0] cmd, input logic [63:0] hash,
                            input logic typed, input logic typed_present);
        logic        hit;
        bbf_result_t r;
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= hash;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        hit       = filter_apply(cmd, hash);
        r.present = typed ? typed_present : hit;
        r.cmd     = cmd;
        pending_results.push_back(r);
        n_keys++;
        if (cmd == bbf_pkg::CMD_CLEAR)
            n_clears++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_block_count(input logic [10:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid     <= 1'b0;
        block_count_q  = value;
    endtask

    // output side: random stalls plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_seen != hold_reqs) begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready  <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing pending: maybe_present %0d done_command %0d",
                       m_tdata[0], m_tuser);
                err_cnt++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[0] !== want.present) begin
                    $error("maybe_present: expected %0d, got %0d", want.present, m_tdata[0]);
                    err_cnt++;
                end
                if (m_tuser !== want.cmd) begin
                    $error("done_command: expected %0d, got %0d", want.cmd, m_tuser);
                    err_cnt++;
                end
                n_checked++;
                if (m_tdata[0] === 1'b1)
                    n_hits++;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
            $display("tb_blocked_bloom_filter_core: errors");
            $finish;
        end
    end

    initial begin
        logic [1:0]  cmd;
        logic [63:0] hash;
        int          pick;
        foreach (filter_q[b])
            filter_q[b] = '0;
        block_count_q = bbf_pkg::COUNT_RESET;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < DIR_LEN; r++) begin
            if (dir_rows[r].kind == ROW_CFG)
                write_block_count(dir_rows[r].count);
            else
                send_key(dir_rows[r].cmd, dir_rows[r].hash, dir_rows[r].typed,
                         dir_rows[r].present);
        end

        phase_count[PHASES-1] = 11'($urandom_range(2, 1023));
        for (int ph = 0; ph < PHASES; ph++) begin
            write_block_count(phase_count[ph]);
            idle_pct   = phase_idle[ph];
            stall_pct <= phase_stall[ph];
            known_keys.delete();
            if (ph == 0)
                hold_reqs <= hold_reqs + 1;
            repeat (PHASE_KEYS) begin
                pick = $urandom_range(99);
                hash = {$urandom, $urandom};
                if (pick < 45) begin
                    cmd = bbf_pkg::CMD_ADD;
                    known_keys.push_back(hash);
                    if (known_keys.size() > KNOWN_KEYS)
                        void'(known_keys.pop_front());
                end else if (pick < 90) begin
                    cmd = bbf_pkg::CMD_CHECK;
                    // half the checks revisit an added key so hits show up
                    if (known_keys.size() != 0 && $urandom_range(1) == 1)
                        hash = known_keys[$urandom_range(known_keys.size() - 1)];
                end else if (pick < 96) begin
                    cmd = CMD_UNUSED;
                end else begin
                    cmd = bbf_pkg::CMD_CLEAR;
                end
                send_key(cmd, hash, 1'b0, 1'b0);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("%0d keys sent, %0d results checked, %0d reported present, %0d clears",
                 n_keys, n_checked, n_hits, n_clears);
        $display("block counts 0 to 2047 with saturation, mixed idling and a long output hold-off");
        if (err_cnt == 0)
            $display("tb_blocked_bloom_filter_core: clean");
        else
            $display("tb_blocked_bloom_filter_core: errors");
        $finish;
    end

endmodule
